### rtl/core/exact_color_palette_indexer_defines.svh
// Assertion macros used by the checker of this block.
`ifndef EXACT_COLOR_PALETTE_INDEXER_DEFINES_SVH
`define EXACT_COLOR_PALETTE_INDEXER_DEFINES_SVH

// Clocked check, off while reset is asserted.
`define ECPI_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ECPI_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/ecpi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ecpi_pkg;

	localparam int PALETTE_DEPTH = 256;
	localparam int IDX_W         = $clog2(PALETTE_DEPTH);
	localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);
	localparam int COLOR_W       = 24;
	localparam int TOTAL_W       = 25;
	localparam int PCNT_W        = 24;
	localparam int SLOT_W        = 8;
	localparam int USED_W        = 9;

	localparam logic [1:0] OP_PIXEL = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_START = 2'd2;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] entry_select;
	} pixel_t;

	typedef struct packed {
		logic [SLOT_W-1:0] color_slot;
		logic              status;
		logic              overflow_seen;
		logic              image_complete;
		logic [USED_W-1:0] colors_used;
		logic [7:0]        entry_red;
		logic [7:0]        entry_green;
		logic [7:0]        entry_blue;
	} result_t;

	// Item walking down the cell row.
	typedef struct packed {
		logic [1:0]         opcode;
		logic [COLOR_W-1:0] color;
		logic [7:0]         sel;
		logic               found;
		logic [IDX_W-1:0]   slot;
		logic [COLOR_W-1:0] rd;
	} token_t;

	// Palette insert broadcast to the cells.
	typedef struct packed {
		logic               en;
		logic [IDX_W-1:0]   idx;
		logic [COLOR_W-1:0] color;
	} wr_t;

endpackage
`default_nettype wire

### rtl/core/ecpi_pixel_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ecpi_pixel_if;
	logic            valid;
	logic            ready;
	ecpi_pkg::pixel_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/ecpi_result_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ecpi_result_if;
	logic              valid;
	logic              ready;
	ecpi_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/exact_color_palette_indexer.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   dir   handshake      beat
// pixel     in    valid/ready    opcode, red, green, blue, entry_select
// result    out   valid/ready    slot, status, flags, colors_used, entry color
// cfg       in    cfg_we         cfg_data = pixel_total
//
// One item at a time: a beat walks the row of PALETTE_DEPTH match cells, one
// cell per cycle, then a done stage updates the palette and counters, and the
// next item is accepted only once that done stage has fired.
// Reset clears the counters, flags and beat valids; palette colors are not reset.
// A result that is not taken holds the done stage; the next pixel is taken
// while a finished result waits, until that item itself reaches the done stage.
module exact_color_palette_indexer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	ecpi_pixel_if.sink                         pixel,
	ecpi_result_if.source                      result,
	input  wire logic                          cfg_we,
	input  wire logic [ecpi_pkg::TOTAL_W-1:0]  cfg_data
);

	localparam int D = ecpi_pkg::PALETTE_DEPTH;

	logic [ecpi_pkg::CNT_W-1:0]   cnt_q;
	logic [ecpi_pkg::PCNT_W-1:0]  pcnt_q;
	logic                         ovf_q;
	logic [ecpi_pkg::TOTAL_W-1:0] total_q;
	logic                         busy_q;
	logic                         done_vld_q;
	ecpi_pkg::token_t             done_tok_q;
	logic                         res_vld_q;
	ecpi_pkg::result_t            res_q;

	logic                         accept;
	logic                         fire;
	logic                         tok_vld [D+1];
	ecpi_pkg::token_t             tok     [D+1];
	ecpi_pkg::wr_t                wr;

	logic [ecpi_pkg::CNT_W-1:0]   cnt_nxt;
	logic [ecpi_pkg::PCNT_W-1:0]  pcnt_nxt;
	logic                         ovf_nxt;
	ecpi_pkg::result_t            res_nxt;
	logic                         last_px;

	assign pixel.ready = !busy_q;
	assign accept      = pixel.valid && !busy_q;
	assign fire        = done_vld_q && (!res_vld_q || result.ready);

	always_comb begin
		tok_vld[0]     = accept;
		tok[0].opcode  = pixel.data.opcode;
		tok[0].color   = {pixel.data.red, pixel.data.green, pixel.data.blue};
		tok[0].sel     = pixel.data.entry_select;
		tok[0].found   = 1'b0;
		tok[0].slot    = '0;
		tok[0].rd      = '0;
	end

	for (genvar k = 0; k < D; k++) begin : g_cell
		ecpi_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.idx       (ecpi_pkg::IDX_W'(k)),
			.count     (cnt_q),
			.wr        (wr),
			.tok_vld_i (tok_vld[k]),
			.tok_i     (tok[k]),
			.tok_vld_o (tok_vld[k+1]),
			.tok_o     (tok[k+1])
		);
	end

	assign last_px = ({1'b0, pcnt_q} + ecpi_pkg::TOTAL_W'(1)) == total_q;

	always_comb begin
		cnt_nxt  = cnt_q;
		pcnt_nxt = pcnt_q;
		ovf_nxt  = ovf_q;
		res_nxt  = '0;
		wr.en    = 1'b0;
		wr.idx   = cnt_q[ecpi_pkg::IDX_W-1:0];
		wr.color = done_tok_q.color;
		case (done_tok_q.opcode)
			ecpi_pkg::OP_PIXEL: begin
				if (done_tok_q.found) begin
					res_nxt.color_slot = ecpi_pkg::SLOT_W'(done_tok_q.slot);
				end else if (cnt_q < ecpi_pkg::CNT_W'(D)) begin
					wr.en              = fire;
					res_nxt.color_slot = ecpi_pkg::SLOT_W'(cnt_q[ecpi_pkg::IDX_W-1:0]);
					cnt_nxt            = cnt_q + ecpi_pkg::CNT_W'(1);
				end else begin
					res_nxt.status = 1'b1;
					ovf_nxt        = 1'b1;
				end
				if (last_px) begin
					res_nxt.image_complete = 1'b1;
					pcnt_nxt               = '0;
				end else begin
					pcnt_nxt = pcnt_q + ecpi_pkg::PCNT_W'(1);
				end
			end
			ecpi_pkg::OP_READ: begin
				res_nxt.entry_red   = done_tok_q.rd[23:16];
				res_nxt.entry_green = done_tok_q.rd[15:8];
				res_nxt.entry_blue  = done_tok_q.rd[7:0];
			end
			ecpi_pkg::OP_START: begin
				cnt_nxt  = '0;
				pcnt_nxt = '0;
				ovf_nxt  = 1'b0;
			end
			default: begin
			end
		endcase
		res_nxt.overflow_seen = ovf_nxt;
		res_nxt.colors_used   = ecpi_pkg::USED_W'(cnt_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			pcnt_q     <= '0;
			ovf_q      <= 1'b0;
			total_q    <= ecpi_pkg::TOTAL_W'(1);
			busy_q     <= 1'b0;
			done_vld_q <= 1'b0;
			res_vld_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				total_q <= cfg_data;
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (fire) begin
				busy_q <= 1'b0;
			end
			// hold the finished beat until the output register frees up
			if (tok_vld[D]) begin
				done_vld_q <= 1'b1;
			end else if (fire) begin
				done_vld_q <= 1'b0;
			end
			if (fire) begin
				cnt_q     <= cnt_nxt;
				pcnt_q    <= pcnt_nxt;
				ovf_q     <= ovf_nxt;
				res_vld_q <= 1'b1;
			end else if (result.ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_vld[D]) begin
			done_tok_q <= tok[D];
		end
		if (fire) begin
			res_q <= res_nxt;
		end
	end

	assign result.valid = res_vld_q;
	assign result.data  = res_q;

endmodule
`default_nettype wire

### rtl/core/ecpi_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module ecpi_cell (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [ecpi_pkg::IDX_W-1:0]   idx,
	input  wire logic [ecpi_pkg::CNT_W-1:0]   count,
	input  wire ecpi_pkg::wr_t                wr,
	input  wire logic                         tok_vld_i,
	input  wire ecpi_pkg::token_t             tok_i,
	output logic                              tok_vld_o,
	output ecpi_pkg::token_t                  tok_o
);

	logic [ecpi_pkg::COLOR_W-1:0] color_q;
	logic                         vld_q;
	ecpi_pkg::token_t             tok_q;
	ecpi_pkg::token_t             tok_nxt;
	logic                         active;

	assign active = ecpi_pkg::CNT_W'(idx) < count;

	always_comb begin
		tok_nxt = tok_i;
		if (active) begin
			if (tok_i.opcode == ecpi_pkg::OP_PIXEL && !tok_i.found && color_q == tok_i.color) begin
				tok_nxt.found = 1'b1;
				tok_nxt.slot  = idx;
			end
			if (tok_i.opcode == ecpi_pkg::OP_READ && tok_i.sel == 8'(idx)) begin
				tok_nxt.rd = color_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && wr.idx == idx) begin
			color_q <= wr.color;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= tok_vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_vld_i) begin
			tok_q <= tok_nxt;
		end
	end

	assign tok_vld_o = vld_q;
	assign tok_o     = tok_q;

endmodule
`default_nettype wire

### rtl/core/ecpi_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "exact_color_palette_indexer_defines.svh"
module ecpi_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic              res_valid,
	input wire logic              res_ready,
	input wire ecpi_pkg::result_t res
);

	`ECPI_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid && $stable(res), "result dropped or changed while stalled")
	`ECPI_ASSERT(a_one_at_a_time, in_valid && in_ready |=> !in_ready, "second beat taken while one is in flight")
	`ECPI_ASSERT(a_drop_full, res_valid && res.status |-> res.overflow_seen && res.color_slot == '0 && res.colors_used == ecpi_pkg::USED_W'(ecpi_pkg::PALETTE_DEPTH), "drop without a full palette")
	`ECPI_ASSERT(a_used_bound, res_valid |-> res.colors_used <= ecpi_pkg::USED_W'(ecpi_pkg::PALETTE_DEPTH), "colors_used beyond palette depth")
	`ECPI_ASSERT_RST(a_reset_idle, !arst_n |-> !res_valid, "result valid during reset")

endmodule

bind exact_color_palette_indexer ecpi_checker u_ecpi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pixel.valid),
	.in_ready  (pixel.ready),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res       (result.data)
);
`default_nettype wire
